// File: src/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared widths, codes and the structs that travel along the cell chain of
// the aging peer table.
// ----------------------------------------------------------------------------
package apt_pkg;

	localparam int ENTRIES    = 8;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int POS_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int ID_W       = 16;
	localparam int ST_W       = 8;
	localparam int TIME_W     = 32;
	localparam int TMO_W      = 16;
	localparam int BIT_W      = 3;
	localparam int EV_W       = 2;
	localparam int LIVE_W     = 4;
	localparam int SELIDX_W   = 3;
	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 16;

	localparam logic [REG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MOVING_BIT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ERROR_BIT  = 2'd3;

	localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EV_W-1:0] EV_SHORT = 2'd2;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET   = 16'd2000;
	localparam logic [BIT_W-1:0] MOVING_BIT_RESET = 3'd0;
	localparam logic [BIT_W-1:0] ERROR_BIT_RESET  = 3'd1;

	// Token handed from cell to cell. Phase A stores and ages, phase B selects.
	typedef struct packed {
		logic             active;
		logic             phase_b;
		logic             claimed;
		logic [CNT_W-1:0] count;
		logic             moving;
		logic             error;
		logic             found;
		logic [ID_W-1:0]  sel;
	} tok_t;

	// Values every cell sees for the event in progress.
	typedef struct packed {
		logic              do_store;
		logic              match_any;
		logic [ID_W-1:0]   rid;
		logic [ST_W-1:0]   rstatus;
		logic [TIME_W-1:0] now;
		logic [TMO_W-1:0]  timeout;
		logic [BIT_W-1:0]  moving_bit;
		logic [BIT_W-1:0]  error_bit;
		logic [POS_W-1:0]  want;
	} bcast_t;

endpackage

// File: src/apt_cell.sv
// ----------------------------------------------------------------------------
// apt_cell
// One table entry. Updates and ages its entry when the phase A token passes,
// and takes part in the live-entry selection when the phase B token passes.
// ----------------------------------------------------------------------------
module apt_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  apt_pkg::bcast_t          bc,
	input  logic [apt_pkg::ID_W-1:0] match_id,
	output logic                     match,
	input  apt_pkg::tok_t            tok_in,
	output apt_pkg::tok_t            tok_out
);
	import apt_pkg::*;

	logic [ID_W-1:0]   id_q;
	logic [ST_W-1:0]   status_q;
	logic [TIME_W-1:0] seen_q;
	tok_t              tok_q;
	tok_t              tok_nx;

	logic              upd_match;
	logic              upd_fill;
	logic [ID_W-1:0]   id_e;
	logic [ST_W-1:0]   st_e;
	logic [TIME_W-1:0] seen_e;
	logic [TIME_W-1:0] age;
	logic              expired;
	logic              live;
	logic              run_a;
	logic              run_b;

	assign match = (id_q == match_id);

	assign run_a = tok_in.active && !tok_in.phase_b;
	assign run_b = tok_in.active && tok_in.phase_b;

	// A matching entry anywhere wins over the first free slot.
	assign upd_match = bc.do_store && bc.match_any && (id_q == bc.rid);
	assign upd_fill  = bc.do_store && !bc.match_any && !tok_in.claimed && (id_q == '0);

	assign id_e    = upd_fill ? bc.rid : id_q;
	assign st_e    = (upd_fill || upd_match) ? bc.rstatus : status_q;
	assign seen_e  = (upd_fill || upd_match) ? bc.now : seen_q;
	assign age     = bc.now - seen_e;
	assign expired = (id_e != '0) && (age > TIME_W'(bc.timeout));
	assign live    = (id_e != '0) && !expired;

	always_comb begin
		tok_nx = tok_in;
		if (run_a) begin
			tok_nx.claimed = tok_in.claimed | upd_fill;
			tok_nx.count   = tok_in.count + CNT_W'(live);
			tok_nx.moving  = tok_in.moving | (live & st_e[bc.moving_bit]);
			tok_nx.error   = tok_in.error | (live & st_e[bc.error_bit]);
		end else if (run_b) begin
			if ((id_q != '0) && !tok_in.found) begin
				if (tok_in.count == CNT_W'(bc.want)) begin
					tok_nx.found = 1'b1;
					tok_nx.sel   = id_q;
				end else begin
					tok_nx.count = tok_in.count + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q     <= '0;
			status_q <= '0;
			seen_q   <= '0;
			tok_q    <= '0;
		end else begin
			tok_q <= tok_nx;
			if (run_a) begin
				id_q     <= expired ? '0 : id_e;
				status_q <= expired ? '0 : st_e;
				seen_q   <= expired ? '0 : seen_e;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// File: src/aging_peer_table_with_selector_core.sv
// ----------------------------------------------------------------------------
// aging_peer_table_with_selector_core
// Peer table of ENTRIES cells chained in a row. A token walks the row once to
// store the report and age the entries, then once more to pick the selected
// live entry. A small sequencer between the passes steps the setup selector.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  report, time, setup, buttons
//   output   out        out_valid / out_stall counts, flags, selection
//   config   in         wr_en                wr_index, wr_data
//
// An event runs two token walks along the cell row, one cell per cycle each.
// A stalled output holds the finished result; the next event is still taken,
// and its result waits in the sequencer until the output register is free.
// Reset clears the table and selector and sets the configuration to its defaults.
// ----------------------------------------------------------------------------
module aging_peer_table_with_selector_core (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            wr_en,
	input  logic [apt_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [apt_pkg::REG_DATA_W-1:0]  wr_data,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            report_valid,
	input  logic [apt_pkg::ID_W-1:0]        report_id,
	input  logic [apt_pkg::ST_W-1:0]        report_status,
	input  logic [apt_pkg::TIME_W-1:0]      now_ms,
	input  logic                            in_setup,
	input  logic [apt_pkg::EV_W-1:0]        button_one_event,
	input  logic [apt_pkg::EV_W-1:0]        button_two_event,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [apt_pkg::LIVE_W-1:0]      live_count,
	output logic                            any_moving,
	output logic                            any_error,
	output logic [apt_pkg::ID_W-1:0]        selected_id,
	output logic [apt_pkg::SELIDX_W-1:0]    selection_index
);
	import apt_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_A_WAIT = 3'd1;
	localparam logic [2:0] ST_SEL    = 3'd2;
	localparam logic [2:0] ST_B_WAIT = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]        state_q;

	logic [ID_W-1:0]   own_id_q;
	logic [TMO_W-1:0]  timeout_q;
	logic [BIT_W-1:0]  mbit_q;
	logic [BIT_W-1:0]  ebit_q;

	logic              do_store_q;
	logic              match_any_q;
	logic [ID_W-1:0]   rid_q;
	logic [ST_W-1:0]   rstatus_q;
	logic [TIME_W-1:0] now_q;
	logic              setup_q;
	logic [EV_W-1:0]   ev1_q;
	logic [EV_W-1:0]   ev2_q;

	logic [CNT_W-1:0]  count_q;
	logic              moving_q;
	logic              error_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  want_q;
	logic              skip_q;
	logic              was_q;
	logic [ID_W-1:0]   sel_q;

	tok_t              launch_q;
	tok_t              launch_nx;
	tok_t              chain [ENTRIES+1];
	logic [ENTRIES-1:0] match_vec;
	bcast_t            bc;
	logic              out_load;

	logic [CNT_W-1:0]  sel_p;
	logic [CNT_W-1:0]  sel_p1;
	logic              sel_skip;
	logic              sel_step;
	logic [POS_W-1:0]  pos_nx;

	assign in_stall = (state_q != ST_IDLE);

	assign bc.do_store   = do_store_q;
	assign bc.match_any  = match_any_q;
	assign bc.rid        = rid_q;
	assign bc.rstatus    = rstatus_q;
	assign bc.now        = now_q;
	assign bc.timeout    = timeout_q;
	assign bc.moving_bit = mbit_q;
	assign bc.error_bit  = ebit_q;
	assign bc.want       = want_q;

	assign chain[0] = launch_q;

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		apt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bc       (bc),
			.match_id (report_id),
			.match    (match_vec[k]),
			.tok_in   (chain[k]),
			.tok_out  (chain[k+1])
		);
	end

	// A token enters the row for one cycle at the start of each pass.
	always_comb begin
		launch_nx = '0;
		if ((state_q == ST_IDLE) && in_valid) begin
			launch_nx.active = 1'b1;
		end else if (state_q == ST_SEL) begin
			launch_nx.active  = 1'b1;
			launch_nx.phase_b = 1'b1;
		end
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	// Selector update, done once the live count of this event is known.
	always_comb begin
		sel_p = CNT_W'(pos_q);
		if ((count_q != '0) && (sel_p >= count_q)) begin
			sel_p = '0;
		end
		sel_skip = skip_q;
		if (setup_q && !was_q) begin
			sel_p    = '0;
			sel_skip = 1'b1;
		end
		sel_step = 1'b0;
		if (setup_q && ((ev1_q != EV_NONE) || (ev2_q != EV_NONE))) begin
			if (sel_skip) begin
				sel_skip = 1'b0;
			end else if ((ev1_q == EV_SHORT) || (ev2_q == EV_SHORT)) begin
				sel_step = 1'b1;
			end
		end
		sel_p1 = sel_p + CNT_W'(1);
		if (sel_step && (count_q != '0)) begin
			sel_p = (sel_p1 >= count_q) ? '0 : sel_p1;
		end
		pos_nx = POS_W'(sel_p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= '0;
			timeout_q <= TIMEOUT_RESET;
			mbit_q    <= MOVING_BIT_RESET;
			ebit_q    <= ERROR_BIT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_OWN_ID:     own_id_q  <= ID_W'(wr_data);
				REG_TIMEOUT:    timeout_q <= TMO_W'(wr_data);
				REG_MOVING_BIT: mbit_q    <= wr_data[BIT_W-1:0];
				REG_ERROR_BIT:  ebit_q    <= wr_data[BIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			launch_q  <= '0;
			pos_q     <= '0;
			want_q    <= '0;
			skip_q    <= 1'b0;
			was_q     <= 1'b0;
			count_q   <= '0;
			moving_q  <= 1'b0;
			error_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			launch_q  <= launch_nx;
			out_valid <= out_load || (out_valid && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						do_store_q  <= report_valid && (report_id != '0) &&
							(report_id != own_id_q);
						match_any_q <= |match_vec;
						rid_q       <= report_id;
						rstatus_q   <= report_status;
						now_q       <= now_ms;
						setup_q     <= in_setup;
						ev1_q       <= button_one_event;
						ev2_q       <= button_two_event;
						state_q     <= ST_A_WAIT;
					end
				end
				ST_A_WAIT: begin
					if (chain[ENTRIES].active) begin
						count_q  <= chain[ENTRIES].count;
						moving_q <= chain[ENTRIES].moving;
						error_q  <= chain[ENTRIES].error;
						state_q  <= ST_SEL;
					end
				end
				ST_SEL: begin
					pos_q   <= pos_nx;
					skip_q  <= sel_skip;
					was_q   <= setup_q;
					want_q  <= setup_q ? pos_nx : '0;
					state_q <= ST_B_WAIT;
				end
				ST_B_WAIT: begin
					if (chain[ENTRIES].active) begin
						sel_q   <= chain[ENTRIES].sel;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						live_count      <= LIVE_W'(count_q);
						any_moving      <= moving_q;
						any_error       <= error_q;
						selected_id     <= sel_q;
						selection_index <= SELIDX_W'(pos_q);
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The token leaves the last cell only while the sequencer waits for it.
	a_token_return: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ENTRIES].active |-> (state_q == ST_A_WAIT || state_q == ST_B_WAIT))
		else $error("token returned outside a wait state");

	// The live count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL) |-> (count_q <= CNT_W'(ENTRIES)))
		else $error("live count beyond table size");

	// After a selector update the index points inside the live entries.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL && count_q != '0) |=> (CNT_W'(pos_q) < count_q))
		else $error("selection index beyond live count");
`endif

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aging peer table with setup selector. A driver
// feeds peer events from a queue, an in-bench model of the table predicts the
// status of every event, and a monitor compares each output transfer field by
// field. Phases change the node id, the timeout and the flag bit positions
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import apt_pkg::*;

	localparam logic [EV_W-1:0] EV_LONG   = 2'd1;
	localparam logic [EV_W-1:0] EV_UNUSED = 2'd3;
	localparam int LONG_HOLD  = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int POOL_SIZE  = 10;

	typedef struct packed {
		logic              rv;
		logic [ID_W-1:0]   id;
		logic [ST_W-1:0]   st;
		logic [TIME_W-1:0] now;
		logic              setup;
		logic [EV_W-1:0]   b1;
		logic [EV_W-1:0]   b2;
	} peer_event_t;

	typedef struct packed {
		logic [LIVE_W-1:0]   live;
		logic                moving;
		logic                error;
		logic [ID_W-1:0]     sel;
		logic [SELIDX_W-1:0] idx;
	} table_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [REG_DATA_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	peer_event_t cur_ev = '0;
	logic [LIVE_W-1:0] live_count;
	logic any_moving;
	logic any_error;
	logic [ID_W-1:0] selected_id;
	logic [SELIDX_W-1:0] selection_index;

	peer_event_t pending_events[$];
	table_status_t awaited_status[$];

	// Model copy of the registers and the table.
	logic [ID_W-1:0]   cfg_own = '0;
	logic [TMO_W-1:0]  cfg_tmo = TIMEOUT_RESET;
	logic [BIT_W-1:0]  cfg_mbit = MOVING_BIT_RESET;
	logic [BIT_W-1:0]  cfg_ebit = ERROR_BIT_RESET;
	logic [ID_W-1:0]   tbl_id[ENTRIES];
	logic [ST_W-1:0]   tbl_st[ENTRIES];
	logic [TIME_W-1:0] tbl_seen[ENTRIES];
	int   sel_pos = 0;
	logic was_setup = 1'b0;
	logic skip_press = 1'b0;

	// Stimulus generator state.
	logic [TIME_W-1:0] gen_t = '0;
	logic [ID_W-1:0]   gen_own = '0;
	int   gen_tmo = int'(TIMEOUT_RESET);
	logic gen_setup = 1'b0;
	logic [ID_W-1:0] id_pool[POOL_SIZE];

	logic in_took = 1'b0;
	logic calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int go_left = 0;
	int hold_req = 0;
	int hold_done = 0;
	int idle_cycles = 0;
	int events_sent = 0;
	int results_seen = 0;
	int fails = 0;
	int phases = 0;

	aging_peer_table_with_selector_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.report_valid    (cur_ev.rv),
		.report_id       (cur_ev.id),
		.report_status   (cur_ev.st),
		.now_ms          (cur_ev.now),
		.in_setup        (cur_ev.setup),
		.button_one_event(cur_ev.b1),
		.button_two_event(cur_ev.b2),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.live_count      (live_count),
		.any_moving      (any_moving),
		.any_error       (any_error),
		.selected_id     (selected_id),
		.selection_index (selection_index)
	);

	always #5 clk = ~clk;

	initial begin
		for (int k = 0; k < ENTRIES; k++) begin
			tbl_id[k] = '0;
			tbl_st[k] = '0;
			tbl_seen[k] = '0;
		end
	end

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] d);
		case (idx)
			REG_OWN_ID:     cfg_own = d;
			REG_TIMEOUT:    cfg_tmo = d;
			REG_MOVING_BIT: cfg_mbit = d[BIT_W-1:0];
			REG_ERROR_BIT:  cfg_ebit = d[BIT_W-1:0];
			default: ;
		endcase
	endfunction

	// Store the report, age the table, step the selector and pick the entry.
	function automatic table_status_t advance_table(peer_event_t e);
		table_status_t r;
		int k, hit, cnt, want, seen;
		logic mv, er;
		logic [ID_W-1:0] sel;
		logic [TIME_W-1:0] age;
		hit = -1;
		cnt = 0;
		seen = 0;
		mv = 1'b0;
		er = 1'b0;
		sel = '0;
		if (e.rv && e.id != '0 && e.id != cfg_own) begin
			for (k = 0; k < ENTRIES; k++)
				if (hit < 0 && tbl_id[k] == e.id)
					hit = k;
			for (k = 0; k < ENTRIES; k++)
				if (hit < 0 && tbl_id[k] == '0)
					hit = k;
			if (hit >= 0) begin
				tbl_id[hit] = e.id;
				tbl_st[hit] = e.st;
				tbl_seen[hit] = e.now;
			end
		end
		for (k = 0; k < ENTRIES; k++) begin
			if (tbl_id[k] != '0) begin
				age = e.now - tbl_seen[k];
				if (age > TIME_W'(cfg_tmo)) begin
					tbl_id[k] = '0;
					tbl_st[k] = '0;
					tbl_seen[k] = '0;
				end else begin
					cnt++;
					mv |= tbl_st[k][cfg_mbit];
					er |= tbl_st[k][cfg_ebit];
				end
			end
		end
		if (cnt > 0 && sel_pos >= cnt)
			sel_pos = 0;
		if (e.setup && !was_setup) begin
			sel_pos = 0;
			skip_press = 1'b1;
		end
		if (e.setup && (e.b1 != EV_NONE || e.b2 != EV_NONE)) begin
			if (skip_press) begin
				skip_press = 1'b0;
			end else if ((e.b1 == EV_SHORT || e.b2 == EV_SHORT) && cnt > 0) begin
				sel_pos++;
				if (sel_pos >= cnt)
					sel_pos = 0;
			end
		end
		was_setup = e.setup;
		want = e.setup ? sel_pos : 0;
		for (k = 0; k < ENTRIES; k++) begin
			if (tbl_id[k] != '0) begin
				if (seen == want)
					sel = tbl_id[k];
				seen++;
			end
		end
		r.live = cnt[LIVE_W-1:0];
		r.moving = mv;
		r.error = er;
		r.sel = sel;
		r.idx = sel_pos[SELIDX_W-1:0];
		return r;
	endfunction

	// Driver: a new event is offered only after the previous one transferred.
	always @(negedge clk) begin
		logic nv;
		peer_event_t nx;
		nv = in_valid;
		nx = cur_ev;
		if (arst_n && (!in_valid || in_took)) begin
			nv = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_events.size() != 0) begin
				nx = pending_events.pop_front();
				nv = 1'b1;
				send_gap = calm ? 0 : next_gap();
			end
		end
		in_valid <= nv;
		cur_ev <= nx;
	end

	// Receiver stall pattern, with a long hold-off on request.
	always @(negedge clk) begin
		logic s;
		if (hold_done != hold_req) begin
			hold_done = hold_req;
			stall_left = LONG_HOLD;
		end
		if (stall_left == 0 && go_left == 0) begin
			stall_left = calm ? 0 : next_gap();
			go_left = $urandom_range(1, 8);
		end
		if (stall_left > 0) begin
			stall_left--;
			s = 1'b1;
		end else begin
			go_left--;
			s = 1'b0;
		end
		out_stall <= s;
	end

	// Monitor: predicts on every input transfer, checks every output transfer.
	always @(posedge clk) begin
		table_status_t want;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			if (wr_en)
				apply_reg(wr_index, wr_data);
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				awaited_status.push_back(advance_table(cur_ev));
				events_sent++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (awaited_status.size() == 0) begin
					$error("result transfer with no event outstanding");
					fails++;
				end else begin
					want = awaited_status.pop_front();
					if (live_count !== want.live) begin
						$error("live_count: expected %0d, actual %0d", want.live, live_count);
						fails++;
					end
					if (any_moving !== want.moving) begin
						$error("any_moving: expected %0d, actual %0d", want.moving, any_moving);
						fails++;
					end
					if (any_error !== want.error) begin
						$error("any_error: expected %0d, actual %0d", want.error, any_error);
						fails++;
					end
					if (selected_id !== want.sel) begin
						$error("selected_id: expected %h, actual %h", want.sel, selected_id);
						fails++;
					end
					if (selection_index !== want.idx) begin
						$error("selection_index: expected %0d, actual %0d", want.idx,
							selection_index);
						fails++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic peer_event_t mk_ev(logic rv, logic [ID_W-1:0] id, logic [ST_W-1:0] st,
		logic [TIME_W-1:0] now, logic setup, logic [EV_W-1:0] b1, logic [EV_W-1:0] b2);
		peer_event_t e;
		e.rv = rv;
		e.id = id;
		e.st = st;
		e.now = now;
		e.setup = setup;
		e.b1 = b1;
		e.b2 = b2;
		return e;
	endfunction

	function automatic logic [EV_W-1:0] pick_button();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return EV_NONE;
		if (r < 75)
			return EV_SHORT;
		if (r < 90)
			return EV_LONG;
		return EV_UNUSED;
	endfunction

	task automatic gen_random_event();
		peer_event_t e;
		int r;
		e = '0;
		r = $urandom_range(0, 99);
		if (r < 5)
			gen_t += gen_tmo + $urandom_range(1, 3);
		else if (r < 8)
			gen_t += gen_tmo;
		else if (r < 10)
			gen_t = $urandom();
		else
			gen_t += $urandom_range(0, gen_tmo / 4 + 1);
		e.now = gen_t;
		e.st = ST_W'($urandom());
		r = $urandom_range(0, 99);
		e.rv = (r >= 70 && r < 78) ? 1'b0 : 1'b1;
		if (r < 78)
			e.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 83)
			e.id = gen_own;
		else if (r < 86)
			e.id = '0;
		else
			e.id = ID_W'($urandom());
		if ($urandom_range(0, 99) < 12)
			gen_setup = !gen_setup;
		e.setup = gen_setup;
		if (gen_setup || $urandom_range(0, 99) < 20) begin
			e.b1 = pick_button();
			e.b2 = ($urandom_range(0, 99) < 70) ? EV_NONE : pick_button();
		end
		pending_events.push_back(e);
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0 || in_valid || awaited_status.size() != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] d);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic new_pool();
		for (int k = 0; k < POOL_SIZE; k++)
			id_pool[k] = ID_W'($urandom_range(1, 65535));
		id_pool[0] = gen_own;
		id_pool[1] = 16'hFFFF;
	endtask

	// Reconfigures the idle block, then queues one phase of random events.
	task automatic run_phase(logic [ID_W-1:0] own, logic [TMO_W-1:0] tmo,
		logic [REG_DATA_W-1:0] mb_word, logic [REG_DATA_W-1:0] eb_word,
		logic [TIME_W-1:0] t0, int n, logic hold, logic quiet);
		wait_drained();
		write_reg(REG_OWN_ID, own);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_MOVING_BIT, mb_word);
		write_reg(REG_ERROR_BIT, eb_word);
		gen_own = own;
		gen_tmo = int'(tmo);
		gen_t = t0;
		calm = quiet;
		new_pool();
		repeat (n) gen_random_event();
		if (hold)
			hold_req++;
		phases++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed events under the reset register values.
		pending_events.push_back(mk_ev(1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b0, 16'h0005, 8'hFF, 32'h1, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'h0000, 8'hFF, 32'h2, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'hFFFF, 8'hFF, 32'd10, 1'b0, EV_NONE, EV_NONE));
		for (int k = 1; k < ENTRIES; k++)
			pending_events.push_back(mk_ev(1'b1, ID_W'(k), 8'(k * 37), 32'd10, 1'b0,
				EV_NONE, EV_NONE));
		// The table is full now, so this new id is dropped.
		pending_events.push_back(mk_ev(1'b1, 16'd100, 8'h00, 32'd10, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'd3, 8'h00, 32'd1000, 1'b0, EV_NONE, EV_NONE));
		// Age exactly equal to the timeout keeps an entry, one more drops it.
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2010, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2011, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'd20, 8'h80, 32'd2011, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'd21, 8'h00, 32'd2011, 1'b0, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'd22, 8'h03, 32'd2011, 1'b0, EV_NONE, EV_NONE));
		// Entering setup arms the skip; the unused code only clears it.
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2012, 1'b1, EV_NONE, EV_NONE));
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2012, 1'b1, EV_UNUSED,
			EV_NONE));
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2013, 1'b1, EV_SHORT, EV_NONE));
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2013, 1'b1, EV_NONE, EV_SHORT));
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2014, 1'b1, EV_SHORT, EV_SHORT));
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'd2014, 1'b1, EV_SHORT, EV_LONG));
		// Leaving setup ignores the press; the far time ages everything out.
		pending_events.push_back(mk_ev(1'b0, 16'd0, 8'h00, 32'hFFFF_FFFF, 1'b0, EV_SHORT,
			EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'd9, 8'h02, 32'hFFFF_FF00, 1'b1, EV_SHORT,
			EV_NONE));
		pending_events.push_back(mk_ev(1'b1, 16'd7, 8'h01, 32'h0000_0100, 1'b1, EV_SHORT,
			EV_NONE));

		gen_t = 32'd5000;
		new_pool();
		repeat (100) gen_random_event();
		phases++;

		run_phase(16'h1234, 16'd300, 16'd7, 16'd0, 32'd0, 170, 1'b0, 1'b0);
		run_phase(16'hFFFF, 16'd0, 16'd3, 16'd3, 32'h8000_0000, 170, 1'b0, 1'b0);
		run_phase(16'h0000, 16'hFFFF, 16'hFFF8, 16'hA5AF, 32'h1000_0000, 170, 1'b0, 1'b0);
		run_phase(16'h00A5, 16'd50, 16'd5, 16'd6, 32'hFFFF_FF80, 170, 1'b1, 1'b0);
		run_phase(16'h5A5A, 16'd1000, 16'd1, 16'd2, 32'h0123_4567, 170, 1'b0, 1'b1);
		run_phase(16'h8001, 16'hFFFF, 16'd4, 16'd7, 32'hFFFF_0000, 170, 1'b0, 1'b0);

		wait_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d events and %0d results over %0d register settings",
			events_sent, results_seen, phases);
		$display("including a long receiver hold-off and a clock wrap, %0d mismatches", fails);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
